### hw/rtl/icfe_pkg.sv
package icfe_pkg;

    // Lattice geometry
    localparam int SIDE_BITS = 4;
    localparam int ADDR_W    = 3 * SIDE_BITS;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int CNT_W     = ADDR_W + 1;

    // Field widths
    localparam int REQ_W        = 2;
    localparam int POS_W        = 4;
    localparam int SIZE_W       = 13;
    localparam int THR_W        = 17;
    localparam int SEED_W       = 32;
    localparam int DRAW_W       = 16;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_PAD_W    = OUT_TDATA_W - SIZE_W - 1;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 1'b1;

    // Neighbor visit order
    localparam logic [2:0] NB_XM = 3'd0;
    localparam logic [2:0] NB_XP = 3'd1;
    localparam logic [2:0] NB_YM = 3'd2;
    localparam logic [2:0] NB_YP = 3'd3;
    localparam logic [2:0] NB_ZM = 3'd4;
    localparam logic [2:0] NB_ZP = 3'd5;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } t_spin_wr;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] data;
    } t_queue_wr;

    function automatic logic [ADDR_W-1:0] site_of(input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] y,
                                                  input logic [POS_W-1:0] z);
        return {SIDE_BITS'(x), SIDE_BITS'(y), SIDE_BITS'(z)};
    endfunction

    // Periodic neighbor k of site cur
    function automatic logic [ADDR_W-1:0] nb_site(input logic [ADDR_W-1:0] cur,
                                                  input logic [2:0] k);
        logic [SIDE_BITS-1:0] cx;
        logic [SIDE_BITS-1:0] cy;
        logic [SIDE_BITS-1:0] cz;
        cx = cur[3*SIDE_BITS-1:2*SIDE_BITS];
        cy = cur[2*SIDE_BITS-1:SIDE_BITS];
        cz = cur[SIDE_BITS-1:0];
        case (k)
            NB_XM:   cx = cx - SIDE_BITS'(1);
            NB_XP:   cx = cx + SIDE_BITS'(1);
            NB_YM:   cy = cy - SIDE_BITS'(1);
            NB_YP:   cy = cy + SIDE_BITS'(1);
            NB_ZM:   cz = cz - SIDE_BITS'(1);
            NB_ZP:   cz = cz + SIDE_BITS'(1);
            default: cx = cx;
        endcase
        return {cx, cy, cz};
    endfunction

    function automatic logic [SIZE_W-1:0] sat_size(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        if (w > 32'(SIZE_MAX)) begin
            return SIZE_MAX;
        end
        return SIZE_W'(w);
    endfunction

endpackage

### hw/rtl/icfe_ram.sv
module icfe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/icfe_rng.sv
module icfe_rng (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [icfe_pkg::SEED_W-1:0]   i_seed,
    input  logic                          i_step,
    output logic [icfe_pkg::DRAW_W-1:0]   o_draw
);
    import icfe_pkg::*;

    logic [SEED_W-1:0] r_state;
    logic [SEED_W-1:0] n_state;

    // xorshift32 successor of the current state
    always_comb begin
        n_state = r_state;
        n_state = n_state ^ (n_state << 13);
        n_state = n_state ^ (n_state >> 17);
        n_state = n_state ^ (n_state << 5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEED_W'(1);
        end else if (i_load) begin
            r_state <= i_seed;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_draw = n_state[DRAW_W-1:0];

endmodule

### hw/rtl/icfe_seq.sv
module icfe_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [icfe_pkg::REQ_W-1:0]      i_req,
    input  logic [icfe_pkg::POS_W-1:0]      i_pos_x,
    input  logic [icfe_pkg::POS_W-1:0]      i_pos_y,
    input  logic [icfe_pkg::POS_W-1:0]      i_pos_z,
    input  logic                            i_spin_in,
    // result side
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [icfe_pkg::SIZE_W-1:0]     o_cluster_size,
    output logic                            o_spin_out,
    // bond test
    input  logic [icfe_pkg::THR_W-1:0]      i_threshold,
    input  logic [icfe_pkg::DRAW_W-1:0]     i_draw,
    output logic                            o_rng_step,
    // spin store
    output icfe_pkg::t_spin_wr              o_spin_wr,
    output logic [icfe_pkg::ADDR_W-1:0]     o_spin_raddr,
    input  logic                            i_spin_rdata,
    // frontier queue
    output icfe_pkg::t_queue_wr             o_queue_wr,
    output logic [icfe_pkg::ADDR_W-1:0]     o_queue_raddr,
    input  logic [icfe_pkg::ADDR_W-1:0]     i_queue_rdata
);
    import icfe_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_START, S_SEED, S_POP, S_CUR, S_NB_RD, S_NB_EV, S_DONE
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [REQ_W-1:0]   r_req;
    logic [ADDR_W-1:0]  r_site;
    logic               r_spin_in;
    logic               r_orig;
    logic               r_spin_res;
    logic [CNT_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_cur;
    logic [2:0]         r_k;
    logic               r_out_valid;
    logic [SIZE_W-1:0]  r_out_size;
    logic               r_out_spin;

    logic [ADDR_W-1:0]  w_nb;
    logic               w_match;
    logic               w_join;

    assign w_nb    = nb_site(r_cur, r_k);
    assign w_match = (i_spin_rdata == r_orig);
    assign w_join  = (r_state == S_NB_EV) && w_match && (THR_W'(i_draw) < i_threshold);

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cluster_size = r_out_size;
    assign o_spin_out     = r_out_spin;
    assign o_rng_step     = (r_state == S_NB_EV) && w_match;
    assign o_spin_raddr   = (r_state == S_START) ? r_site : w_nb;
    assign o_queue_raddr  = r_head[ADDR_W-1:0];

    always_comb begin
        o_spin_wr  = '{we: 1'b0, addr: w_nb, data: ~r_orig};
        o_queue_wr = '{we: 1'b0, addr: r_tail[ADDR_W-1:0], data: w_nb};
        case (r_state)
            S_CLEAR: begin
                o_spin_wr = '{we: 1'b1, addr: r_clr_addr, data: 1'b0};
            end
            S_START: begin
                o_spin_wr = '{we: (r_req == REQ_WRITE), addr: r_site, data: r_spin_in};
            end
            S_SEED: begin
                o_spin_wr  = '{we: (r_req == REQ_UPDATE), addr: r_site, data: ~i_spin_rdata};
                o_queue_wr = '{we: (r_req == REQ_UPDATE), addr: '0, data: r_site};
            end
            S_NB_EV: begin
                o_spin_wr.we  = w_join;
                o_queue_wr.we = w_join;
            end
            default: begin
                o_spin_wr.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req     <= i_req;
                        r_site    <= site_of(i_pos_x, i_pos_y, i_pos_z);
                        r_spin_in <= i_spin_in;
                        r_state   <= S_START;
                    end
                end
                S_START: begin
                    if (r_req inside {REQ_READ, REQ_UPDATE}) begin
                        r_state <= S_SEED;
                    end else begin
                        r_count    <= '0;
                        r_spin_res <= 1'b0;
                        r_state    <= S_DONE;
                    end
                end
                S_SEED: begin
                    r_spin_res <= i_spin_rdata;
                    r_orig     <= i_spin_rdata;
                    if (r_req == REQ_UPDATE) begin
                        r_head  <= '0;
                        r_tail  <= CNT_W'(1);
                        r_count <= CNT_W'(1);
                        r_state <= S_POP;
                    end else begin
                        r_count <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_POP: begin
                    if (r_head == r_tail) begin
                        r_state <= S_DONE;
                    end else begin
                        r_head  <= r_head + CNT_W'(1);
                        r_state <= S_CUR;
                    end
                end
                S_CUR: begin
                    r_cur   <= i_queue_rdata;
                    r_k     <= NB_XM;
                    r_state <= S_NB_RD;
                end
                S_NB_RD: begin
                    r_state <= S_NB_EV;
                end
                S_NB_EV: begin
                    if (w_join) begin
                        r_tail  <= r_tail + CNT_W'(1);
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (r_k == NB_ZP) begin
                        r_state <= S_POP;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_NB_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_size  <= sat_size(r_count);
                        r_out_spin  <= r_spin_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/ising_cluster_flip_engine_core.sv
// Channel   | Direction | Handshake                     | Payload
// --------- | --------- | ----------------------------- | --------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser: req_type; tdata: pos_x,
//           |           |                               |   pos_y, pos_z, spin_in
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: cluster_size, spin_out
// cfg       | in        | i_cfg_we (no wait)            | i_cfg_index, i_cfg_data
//
// Steps: a write or unknown request passes through S_START and S_DONE, a read
//   also through S_SEED, and an update also walks the cluster: each member costs
//   a frontier-queue read plus a read step and an evaluate step on the spin store
//   for each of its six neighbors. One item is in work at a time; one more result
//   can wait in the output register while the next item is taken.
// Reset: synchronous, active low. After reset the spin store is swept to zero,
//   one site per cycle, with s_axis_tready low; config writes are
//   taken during the sweep.
// Stalls: a held m_axis_tready holds the finished item in the sequencer until
//   the output register frees up.
module ising_cluster_flip_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // s_axis tdata: [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [12] spin_in, [15:13] zero
    input  logic [icfe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // s_axis tuser: [1:0] req_type
    input  logic [icfe_pkg::REQ_W-1:0]          s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // m_axis tdata: [12:0] cluster_size, [13] spin_out, [15:14] zero
    output logic [icfe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [icfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [icfe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import icfe_pkg::*;

    logic [THR_W-1:0]   r_threshold;
    logic               w_seed_load;
    logic [DRAW_W-1:0]  w_draw;
    logic               w_rng_step;

    t_spin_wr           w_spin_wr;
    logic [ADDR_W-1:0]  w_spin_raddr;
    logic               w_spin_rdata;
    t_queue_wr          w_queue_wr;
    logic [ADDR_W-1:0]  w_queue_raddr;
    logic [ADDR_W-1:0]  w_queue_rdata;

    logic [SIZE_W-1:0]  w_cluster_size;
    logic               w_spin_out;

    // Bond threshold register; the seed register lives in the generator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we && (i_cfg_index == CFG_THRESHOLD)) begin
            r_threshold <= i_cfg_data[THR_W-1:0];
        end
    end

    assign w_seed_load = i_cfg_we && (i_cfg_index == CFG_SEED);

    icfe_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_seed_load),
        .i_seed  (i_cfg_data[SEED_W-1:0]),
        .i_step  (w_rng_step),
        .o_draw  (w_draw)
    );

    // One bit per lattice site
    icfe_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (w_spin_wr.we),
        .i_waddr (w_spin_wr.addr),
        .i_wdata (w_spin_wr.data),
        .i_raddr (w_spin_raddr),
        .o_rdata (w_spin_rdata)
    );

    // Breadth-first frontier; every site enters at most once per update
    icfe_ram #(.WIDTH(ADDR_W), .DEPTH(DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_queue_wr.we),
        .i_waddr (w_queue_wr.addr),
        .i_wdata (w_queue_wr.data),
        .i_raddr (w_queue_raddr),
        .o_rdata (w_queue_rdata)
    );

    icfe_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_req          (s_axis_tuser),
        .i_pos_x        (s_axis_tdata[POS_W-1:0]),
        .i_pos_y        (s_axis_tdata[2*POS_W-1:POS_W]),
        .i_pos_z        (s_axis_tdata[3*POS_W-1:2*POS_W]),
        .i_spin_in      (s_axis_tdata[3*POS_W]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_cluster_size (w_cluster_size),
        .o_spin_out     (w_spin_out),
        .i_threshold    (r_threshold),
        .i_draw         (w_draw),
        .o_rng_step     (w_rng_step),
        .o_spin_wr      (w_spin_wr),
        .o_spin_raddr   (w_spin_raddr),
        .i_spin_rdata   (w_spin_rdata),
        .o_queue_wr     (w_queue_wr),
        .o_queue_raddr  (w_queue_raddr),
        .i_queue_rdata  (w_queue_rdata)
    );

    // Pack the result, zero-fill the top bits
    assign m_axis_tdata = {OUT_PAD_W'(0), w_spin_out, w_cluster_size};

endmodule

### hw/rtl/icfe_checker.sv
module icfe_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [icfe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready
);
    import icfe_pkg::*;

    // Reset starts the clearing sweep: no item taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken while spin store is being cleared");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // One item in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    // A cluster never exceeds the lattice, and the pad stays zero
    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[SIZE_W-1:0]) <= 32'(DEPTH))
                          && (m_axis_tdata[OUT_TDATA_W-1:SIZE_W+1] == '0))
        else $error("result out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind ising_cluster_flip_engine_core icfe_checker u_icfe_checker (.*);
